// ----- design/modexp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_pkg: shared types and constants for the modular exponentiation block
// Operand widths, payload structs, register indexes and the interface between
// the sequencer and the shared modular multiplier.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // operand width of base, modulus, exponent and residue
  localparam int unsigned OpW     = 31;
  // step counter width of one modular multiply (one multiplier bit per step)
  localparam int unsigned CntW    = $clog2(OpW);
  // configuration register index width
  localparam int unsigned CfgIdxW = 2;
  // width of the low part kept in byte mode
  localparam int unsigned ByteW   = 8;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgModulus    = 2'd0,
    CfgExponent   = 2'd1,
    CfgByteResult = 2'd2
  } modexp_cfg_e;

  // input beat
  typedef struct packed {
    logic [OpW-1:0] base_value;
    logic           is_last;
  } modexp_in_t;

  // output beat
  typedef struct packed {
    logic [OpW-1:0] residue;
    logic           last_out;
  } modexp_out_t;

  // request to the shared modular multiplier
  typedef struct packed {
    logic           start;
    logic [OpW-1:0] op_a;
    logic [OpW-1:0] op_b;
  } modexp_mul_req_t;

  // response from the shared modular multiplier
  typedef struct packed {
    logic           done;
    logic [OpW-1:0] prod;
  } modexp_mul_rsp_t;

endpackage
`default_nettype wire

// ----- design/modexp_mulmod.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_mulmod: bit-serial modular multiplier
// Interleaved shift-add-reduce: op_a * op_b mod modulus, one bit of op_b per
// cycle, most significant first. op_a must be below the modulus; op_b is any
// 31-bit value. The result appears with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module modexp_mulmod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  modexp_pkg::modexp_mul_req_t  req_i,
  input  logic [modexp_pkg::OpW-1:0]   modulus_i,
  output modexp_pkg::modexp_mul_rsp_t  rsp_o
);
  import modexp_pkg::*;

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [OpW-1:0]  r_q;
  logic [OpW-1:0]  a_q;
  logic [OpW-1:0]  b_q;

  logic [OpW+1:0]  sum;
  logic [OpW+2:0]  diff1;
  logic [OpW+2:0]  diff2;
  logic [OpW-1:0]  r_next;

  // one step: r = 2r + bit*a, then bring back below the modulus (r < 3m here)
  always_comb begin
    sum   = {1'b0, r_q, 1'b0} + {2'b00, (b_q[OpW-1] ? a_q : '0)};
    diff1 = {1'b0, sum} - {3'b000, modulus_i};
    diff2 = {1'b0, sum} - {2'b00, modulus_i, 1'b0};
    if (!diff2[OpW+2]) begin
      r_next = diff2[OpW-1:0];
    end else if (!diff1[OpW+2]) begin
      r_next = diff1[OpW-1:0];
    end else begin
      r_next = sum[OpW-1:0];
    end
  end

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(OpW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q <= '0;
      a_q <= req_i.op_a;
      b_q <= req_i.op_b;
    end else if (busy_q) begin
      r_q <= r_next;
      b_q <= {b_q[OpW-2:0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = r_q;

endmodule
`default_nettype wire

// ----- design/modular_exponentiation.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation: base^exponent mod modulus for small-key RSA
// Right-to-left square-and-multiply around one shared bit-serial modular
// multiplier, with a registered output beat.
// ----------------------------------------------------------------------------
// Each input beat gives one output beat: base_value raised to the exponent
// register modulo the modulus register (exponent 0 gives 1, exponent 1 gives
// the base unreduced, else a modulus below two gives 0), low 8 bits only
// when byte_result is set. One item is worked on at a time; in_ready_o is
// high only while the block is idle. Every modular multiplication goes
// through the one shift-add-reduce unit (launch, 31 bit steps, hand-back).
// An item needs (L + P) of them, where L is the bit length of the exponent
// and P its number of set bits (the first one reduces the base). The next
// item is accepted while a finished result still waits on the output.
// Configuration writes are always accepted and must only be made while idle.
// ----------------------------------------------------------------------------
module modular_exponentiation (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  modexp_pkg::modexp_in_t             in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output modexp_pkg::modexp_out_t            out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [modexp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [modexp_pkg::OpW-1:0]         cfg_data_i
);
  import modexp_pkg::*;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StReduce = 5'b00010,
    StStep   = 5'b00100,
    StMul    = 5'b01000,
    StDone   = 5'b10000
  } modexp_state_e;

  modexp_state_e   state_q, state_d;

  logic [OpW-1:0]  modulus_q;
  logic [OpW-1:0]  exponent_q;
  logic            byte_mode_q;

  logic [OpW-1:0]  e_q;
  logic [OpW-1:0]  acc_q;
  logic [OpW-1:0]  sq_q;
  logic [OpW-1:0]  res_q;
  logic            last_q;
  logic            acc_done_q;
  logic            mul_is_acc_q;
  logic            out_valid_q;
  modexp_out_t     out_data_q;

  modexp_mul_req_t mul_req;
  modexp_mul_rsp_t mul_rsp;

  logic            in_accept;
  logic            pow_path;
  logic            use_acc;
  logic            out_free;
  logic [OpW-1:0]  res_masked;

  assign in_ready_o  = (state_q == StIdle);
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  // full exponentiation only for exponent >= 2 and modulus >= 2
  assign pow_path    = (exponent_q[OpW-1:1] != '0) && (modulus_q[OpW-1:1] != '0);
  // multiply into the accumulator before squaring when the exponent bit is set
  assign use_acc     = e_q[0] && !acc_done_q;
  assign res_masked  = byte_mode_q ? {{(OpW-ByteW){1'b0}}, res_q[ByteW-1:0]} : res_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= OpW'(2);
      exponent_q  <= OpW'(1);
      byte_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgModulus:    modulus_q   <= cfg_data_i;
        CfgExponent:   exponent_q  <= cfg_data_i;
        CfgByteResult: byte_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // request to the shared multiplier
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.op_a  = sq_q;
    mul_req.op_b  = sq_q;
    unique case (state_q)
      StIdle: begin
        // reduce the base: 1 * base mod modulus
        mul_req.start = in_accept && pow_path;
        mul_req.op_a  = OpW'(1);
        mul_req.op_b  = in_data_i.base_value;
      end
      StStep: begin
        mul_req.start = (e_q != '0);
        mul_req.op_a  = use_acc ? acc_q : sq_q;
      end
      default: ;
    endcase
  end

  modexp_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mul_req),
    .modulus_i (modulus_q),
    .rsp_o     (mul_rsp)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = pow_path ? StReduce : StDone;
        end
      end
      StReduce: begin
        if (mul_rsp.done) begin
          state_d = StStep;
        end
      end
      StStep: begin
        state_d = (e_q == '0) ? StDone : StMul;
      end
      StMul: begin
        if (mul_rsp.done) begin
          state_d = StStep;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      e_q          <= '0;
      acc_done_q   <= 1'b0;
      mul_is_acc_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        e_q        <= exponent_q;
        acc_done_q <= 1'b0;
      end
      if ((state_q == StStep) && mul_req.start) begin
        mul_is_acc_q <= use_acc;
      end
      if ((state_q == StMul) && mul_rsp.done) begin
        if (mul_is_acc_q) begin
          acc_done_q <= 1'b1;
          // last set bit done: the final square is not needed
          if (e_q[OpW-1:1] == '0) begin
            e_q <= '0;
          end
        end else begin
          acc_done_q <= 1'b0;
          e_q        <= {1'b0, e_q[OpW-1:1]};
        end
      end
      // output beat register
      if ((state_q == StDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      last_q <= in_data_i.is_last;
      acc_q  <= OpW'(1);
      if (exponent_q == '0) begin
        res_q <= OpW'(1);
      end else if (exponent_q == OpW'(1)) begin
        res_q <= in_data_i.base_value;
      end else begin
        res_q <= '0;
      end
    end
    if ((state_q == StReduce) && mul_rsp.done) begin
      sq_q <= mul_rsp.prod;
    end
    if ((state_q == StMul) && mul_rsp.done) begin
      if (mul_is_acc_q) begin
        acc_q <= mul_rsp.prod;
      end else begin
        sq_q <= mul_rsp.prod;
      end
    end
    if ((state_q == StStep) && (e_q == '0)) begin
      res_q <= acc_q;
    end
    if ((state_q == StDone) && out_free) begin
      out_data_q.residue  <= res_masked;
      out_data_q.last_out <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// ----- design/modexp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_checker: port-level checks for modular_exponentiation
// Watches the input and output handshakes on the top level ports; bound to the top level.
// ----------------------------------------------------------------------------
module modexp_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_o,
  input  logic                               out_valid_o,
  input  logic                               out_ready_i,
  input  modexp_pkg::modexp_out_t            out_data_o
);
  import modexp_pkg::*;

  // a stalled output beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // a stalled output beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // one item at a time: busy right after an input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  // a new result is handed over only as the block turns idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("output beat appeared while still busy");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (.*);
`default_nettype wire
